[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/wse_pkg.sv]
// ----------------------------------------------------------------------------
// wse_pkg
// Shared types and constants of the pixel edge softener.
// ----------------------------------------------------------------------------
package wse_pkg;

    localparam int DIM_W = 10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pass_status_t;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic [7:0] WHITE_RED = 8'hFF;
    localparam logic [7:0] SOFT_STEP = 8'h28;

endpackage

[rtl/core/white_pixel_edge_softener.sv]
// ----------------------------------------------------------------------------
// white_pixel_edge_softener
// RGB pixel store with coordinate write/read and an in-place softening pass.
// ----------------------------------------------------------------------------
// Pixel write and read commands are taken one per cycle while busy is low;
// each transaction's result (result_valid, colors, status) appears in the
// cycle after acceptance, and a read's colors come straight from the pixel
// memory's registered read port. A run command raises busy and sweeps the
// configured image in raster order over the same single read port and
// single write port: a pixel with no interior direction is only scanned, an
// interior one is read and its red checked, and a white one then has its two
// or four neighbors read and, unless white, written back. Reads never share
// a cycle with a write, so no forwarding is needed. The run's result strobes
// on the cycle busy falls; an empty image finishes the cycle after accept.
// There is no result back-pressure: the receiver must take every strobe.
// ----------------------------------------------------------------------------
module white_pixel_edge_softener
    import wse_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
)
(
    input  logic             clk,
    input  logic             rst_n,

    // command transaction
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       opcode,
    input  logic [8:0]       pos_x,
    input  logic [8:0]       pos_y,
    input  logic [7:0]       red_in,
    input  logic [7:0]       green_in,
    input  logic [7:0]       blue_in,

    // result
    output logic             result_valid,
    output logic [7:0]       red_out,
    output logic [7:0]       green_out,
    output logic [7:0]       blue_out,
    output logic             status,

    // configuration write
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    // config registers
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;

    // command result registers
    logic             cmd_valid_reg;
    logic             cmd_read_reg;
    logic             cmd_status_reg;

    logic             accept;
    logic             in_image;
    logic [ADDR_W-1:0] cmd_addr;
    pixel_t           cmd_pixel;

    logic             pass_start;
    pass_status_t     pass_status;
    logic             eng_rd_en;
    logic [ADDR_W-1:0] eng_rd_addr;
    logic             eng_wr_en;
    logic [ADDR_W-1:0] eng_wr_addr;
    pixel_t           eng_wr_data;

    logic             mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic             mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    pixel_t           mem_wr_data;
    pixel_t           mem_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(512);
            height_reg <= DIM_W'(512);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IDX_WIDTH:  width_reg  <= cfg_data;
                CFG_IDX_HEIGHT: height_reg <= cfg_data;
                default:        width_reg  <= width_reg;
            endcase
        end
    end

    // dimensions above the store's extent saturate to it
    assign width_eff  = (32'(width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_reg;
    assign height_eff = (32'(height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_reg;

    assign accept     = start && !busy;
    assign in_image   = ({1'b0, pos_x} < width_eff) && ({1'b0, pos_y} < height_eff);
    assign pass_start = accept && (opcode == OP_RUN);

    // row-major address, row pitch is the store width
    assign cmd_addr = ADDR_W'(ADDR_W'(pos_y) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(pos_x);

    assign cmd_pixel.red   = red_in;
    assign cmd_pixel.green = green_in;
    assign cmd_pixel.blue  = blue_in;

    // memory port mux: engine owns the ports while the pass runs
    always_comb
    begin
        if (pass_status.busy)
        begin
            mem_rd_en   = eng_rd_en;
            mem_rd_addr = eng_rd_addr;
            mem_wr_en   = eng_wr_en;
            mem_wr_addr = eng_wr_addr;
            mem_wr_data = eng_wr_data;
        end
        else
        begin
            mem_rd_en   = accept && (opcode == OP_READ) && in_image;
            mem_rd_addr = cmd_addr;
            mem_wr_en   = accept && (opcode == OP_WRITE) && in_image;
            mem_wr_addr = cmd_addr;
            mem_wr_data = cmd_pixel;
        end
    end

    wse_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    wse_pass_engine #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (pass_start),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .rd_data    (mem_rd_data),
        .rd_en      (eng_rd_en),
        .rd_addr    (eng_rd_addr),
        .wr_en      (eng_wr_en),
        .wr_addr    (eng_wr_addr),
        .wr_data    (eng_wr_data),
        .status     (pass_status)
    );

    // write, read and ignored opcodes answer on the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= accept && (opcode != OP_RUN);
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_read_reg   <= (opcode == OP_READ) && in_image;
        cmd_status_reg <= ((opcode == OP_WRITE) || (opcode == OP_READ)) && !in_image
                          ? STATUS_OUTSIDE : STATUS_DONE;
    end

    assign busy         = pass_status.busy;
    assign result_valid = cmd_valid_reg || pass_status.done;
    assign status       = cmd_valid_reg ? cmd_status_reg : STATUS_DONE;
    assign red_out      = (cmd_valid_reg && cmd_read_reg) ? mem_rd_data.red : 8'd0;
    assign green_out    = (cmd_valid_reg && cmd_read_reg) ? mem_rd_data.green : 8'd0;
    assign blue_out     = (cmd_valid_reg && cmd_read_reg) ? mem_rd_data.blue : 8'd0;

endmodule

[rtl/core/wse_store.sv]
// ----------------------------------------------------------------------------
// wse_store
// Pixel memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wse_store
    import wse_pkg::*;
#(
    parameter int DEPTH  = 262144,
    parameter int ADDR_W = 18
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pixel_t            wr_data,
    output pixel_t            rd_data
);

    pixel_t mem [DEPTH];
    pixel_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/wse_pass_engine.sv]
// ----------------------------------------------------------------------------
// wse_pass_engine
// Raster sequencer for the softening pass: read each interior center, and
// for a white one read-modify-write each neighbor via the shared memory ports.
// ----------------------------------------------------------------------------
module wse_pass_engine
    import wse_pkg::*;
#(
    parameter int MAX_WIDTH = 512,
    parameter int ADDR_W    = 18
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIM_W-1:0]  width_eff,
    input  logic [DIM_W-1:0]  height_eff,
    input  pixel_t            rd_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output pixel_t            wr_data,
    output pass_status_t      status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CWAIT = 3'd2;
    localparam logic [2:0] S_NRD   = 3'd3;
    localparam logic [2:0] S_NWR   = 3'd4;

    localparam logic [1:0] NB_LEFT  = 2'd0;
    localparam logic [1:0] NB_RIGHT = 2'd1;
    localparam logic [1:0] NB_UP    = 2'd2;
    localparam logic [1:0] NB_DOWN  = 2'd3;

    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(MAX_WIDTH);
    localparam logic [ADDR_W-1:0] ONE_ADDR = ADDR_W'(1);

    logic [2:0]        state_reg, state_next;
    logic [DIM_W-1:0]  x_reg, x_next;
    logic [DIM_W-1:0]  y_reg, y_next;
    logic [ADDR_W-1:0] row_reg, row_next;
    logic [1:0]        nb_reg, nb_next;
    logic              hin_reg, hin_next;
    logic              vin_reg, vin_next;
    logic              done_reg, done_next;

    logic [ADDR_W-1:0] ctr_addr;
    logic [ADDR_W-1:0] nb_addr;
    logic [DIM_W:0]    x_inc;
    logic [DIM_W:0]    y_inc;
    logic              x_last;
    logic              y_last;
    logic              h_int;
    logic              v_int;
    logic              advance;

    assign ctr_addr = row_reg + ADDR_W'(x_reg);
    assign x_inc    = {1'b0, x_reg} + 1'b1;
    assign y_inc    = {1'b0, y_reg} + 1'b1;
    assign x_last   = (x_inc == {1'b0, width_eff});
    assign y_last   = (y_inc == {1'b0, height_eff});
    assign h_int    = (x_reg != '0) && (x_inc < {1'b0, width_eff});
    assign v_int    = (y_reg != '0) && (y_inc < {1'b0, height_eff});

    always_comb
    begin
        case (nb_reg)
            NB_LEFT:  nb_addr = ctr_addr - ONE_ADDR;
            NB_RIGHT: nb_addr = ctr_addr + ONE_ADDR;
            NB_UP:    nb_addr = ctr_addr - ROW_STEP;
            default:  nb_addr = ctr_addr + ROW_STEP;
        endcase
    end

    // softened neighbor, each channel wraps
    assign wr_data.red   = rd_data.red + SOFT_STEP;
    assign wr_data.green = rd_data.green + SOFT_STEP;
    assign wr_data.blue  = rd_data.blue + SOFT_STEP;
    assign wr_addr       = nb_addr;

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        row_next   = row_reg;
        nb_next    = nb_reg;
        hin_next   = hin_reg;
        vin_next   = vin_reg;
        done_next  = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = ctr_addr;
        wr_en      = 1'b0;
        advance    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if ((width_eff == '0) || (height_eff == '0))
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        x_next     = '0;
                        y_next     = '0;
                        row_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (h_int || v_int)
                begin
                    rd_en      = 1'b1;
                    hin_next   = h_int;
                    vin_next   = v_int;
                    state_next = S_CWAIT;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_CWAIT:
            begin
                // softening skips white pixels, so the center stays put
                if (rd_data.red == WHITE_RED)
                begin
                    nb_next    = hin_reg ? NB_LEFT : NB_UP;
                    state_next = S_NRD;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_NRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = nb_addr;
                state_next = S_NWR;
            end
            S_NWR:
            begin
                wr_en = (rd_data.red != WHITE_RED);
                case (nb_reg)
                    NB_LEFT:
                    begin
                        nb_next    = NB_RIGHT;
                        state_next = S_NRD;
                    end
                    NB_RIGHT:
                    begin
                        if (vin_reg)
                        begin
                            nb_next    = NB_UP;
                            state_next = S_NRD;
                        end
                        else
                        begin
                            advance = 1'b1;
                        end
                    end
                    NB_UP:
                    begin
                        nb_next    = NB_DOWN;
                        state_next = S_NRD;
                    end
                    default:
                    begin
                        advance = 1'b1;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (advance)
        begin
            if (x_last)
            begin
                x_next = '0;
                if (y_last)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    y_next     = y_inc[DIM_W-1:0];
                    row_next   = row_reg + ROW_STEP;
                    state_next = S_SCAN;
                end
            end
            else
            begin
                x_next     = x_inc[DIM_W-1:0];
                state_next = S_SCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        row_reg <= row_next;
        nb_reg  <= nb_next;
        hin_reg <= hin_next;
        vin_reg <= vin_next;
    end

    assign status.busy = (state_reg != S_IDLE);
    assign status.done = done_reg;

endmodule

[rtl/core/wse_checker.sv]
// ----------------------------------------------------------------------------
// wse_checker
// Port-level checks of command, pass and result timing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wse_checker
    import wse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [1:0]       opcode,
    input  logic             result_valid,
    input  logic [7:0]       red_out,
    input  logic [7:0]       green_out,
    input  logic [7:0]       blue_out,
    input  logic             status
);

    logic colors_zero;

    assign colors_zero = (red_out == 8'd0) && (green_out == 8'd0) && (blue_out == 8'd0);

    // non-run commands answer in the cycle after acceptance, with no pass started
    `ASSERT_NEXT(a_cmd_result, clk, rst_n, start && !busy && (opcode != OP_RUN), result_valid && !busy)

    // a write never returns colors
    `ASSERT_NEXT(a_write_zero, clk, rst_n, start && !busy && (opcode == OP_WRITE), colors_zero)

    // a run either goes busy or finishes at once on an empty image
    `ASSERT_NEXT(a_run_busy, clk, rst_n, start && !busy && (opcode == OP_RUN), busy || (result_valid && !status))

    // the end of a pass is reported on the cycle busy drops
    `ASSERT_SAME(a_pass_done, clk, rst_n, $fell(busy), result_valid && (status == STATUS_DONE))

    // a rejected coordinate carries no colors
    `ASSERT_SAME(a_reject_zero, clk, rst_n, result_valid && (status == STATUS_OUTSIDE), colors_zero)

endmodule

bind white_pixel_edge_softener wse_checker u_checker (.*);

[tb/white_pixel_edge_softener_checker.sv]
// ----------------------------------------------------------------------------
// white_pixel_edge_softener_checker
// Watches the command, result and config channels of the edge softener,
// keeps its own image and geometry, and scores every result strobe.
// ----------------------------------------------------------------------------
module white_pixel_edge_softener_checker
    import wse_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
)
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             start,
    input  logic             busy,
    input  logic [1:0]       opcode,
    input  logic [8:0]       pos_x,
    input  logic [8:0]       pos_y,
    input  logic [7:0]       red_in,
    input  logic [7:0]       green_in,
    input  logic [7:0]       blue_in,

    input  logic             result_valid,
    input  logic [7:0]       red_out,
    input  logic [7:0]       green_out,
    input  logic [7:0]       blue_out,
    input  logic             status,

    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [DIM_W-1:0] cfg_data,

    output int               error_count,
    output int               pending_count,
    output int               results_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        pixel_t color;
        logic   status;
    } pixel_result_t;

    pixel_t           image_mem [0:MAX_WIDTH*MAX_HEIGHT-1];
    logic [DIM_W-1:0] width_q;
    logic [DIM_W-1:0] height_q;
    pixel_result_t    expected_q [$];
    int               errors;
    int               seen;

    function automatic int clip_dim(logic [DIM_W-1:0] v, int cap);
        return (int'(v) > cap) ? cap : int'(v);
    endfunction

    // add the soften step to one neighbor unless it is already white
    function automatic void bump_pixel(int x, int y);
        int     a;
        pixel_t p;
        a = y * MAX_WIDTH + x;
        p = image_mem[a];
        if (p.red != WHITE_RED)
        begin
            p.red   = p.red + SOFT_STEP;
            p.green = p.green + SOFT_STEP;
            p.blue  = p.blue + SOFT_STEP;
            image_mem[a] = p;
        end
    endfunction

    // in-place raster sweep; later pixels see earlier updates
    function automatic void soften_pass(int w, int h);
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                if (x >= 1 && x + 1 < w && image_mem[y*MAX_WIDTH + x].red == WHITE_RED)
                begin
                    bump_pixel(x - 1, y);
                    bump_pixel(x + 1, y);
                end
                if (y >= 1 && y + 1 < h && image_mem[y*MAX_WIDTH + x].red == WHITE_RED)
                begin
                    bump_pixel(x, y - 1);
                    bump_pixel(x, y + 1);
                end
            end
        end
    endfunction

    function automatic pixel_result_t predict_command();
        pixel_result_t res;
        int            w;
        int            h;
        int            a;
        logic          in_image;
        res      = '0;
        w        = clip_dim(width_q, MAX_WIDTH);
        h        = clip_dim(height_q, MAX_HEIGHT);
        in_image = (int'(pos_x) < w) && (int'(pos_y) < h);
        a        = int'(pos_y) * MAX_WIDTH + int'(pos_x);
        if (opcode == OP_WRITE || opcode == OP_READ)
        begin
            if (!in_image)
                res.status = STATUS_OUTSIDE;
            else if (opcode == OP_WRITE)
                image_mem[a] = '{red: red_in, green: green_in, blue: blue_in};
            else
                res.color = image_mem[a];
        end
        else if (opcode == OP_RUN)
        begin
            soften_pass(w, h);
        end
        return res;
    endfunction

    function automatic void report(string what, pixel_result_t want, pixel_result_t got);
        if (errors < MAX_REPORTS)
            $display("%t %s: expected r=%02h g=%02h b=%02h st=%0d, got r=%02h g=%02h b=%02h st=%0d",
                     $realtime, what, want.color.red, want.color.green, want.color.blue,
                     want.status, got.color.red, got.color.green, got.color.blue, got.status);
        errors++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t got;
        pixel_result_t want;
        if (!rst_n)
        begin
            width_q  = 10'd512;
            height_q = 10'd512;
            expected_q.delete();
            errors   = 0;
            seen     = 0;
        end
        else
        begin
            if (result_valid)
            begin
                got = '{color: '{red: red_out, green: green_out, blue: blue_out},
                        status: status};
                seen++;
                if (expected_q.size() == 0)
                begin
                    report("result with no transaction pending", '0, got);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.color.red != want.color.red ||
                        got.color.green != want.color.green ||
                        got.color.blue != want.color.blue ||
                        got.status != want.status)
                        report("result mismatch", want, got);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_IDX_WIDTH)
                    width_q = cfg_data;
                else
                    height_q = cfg_data;
            end
            if (start && !busy)
                expected_q.push_back(predict_command());
        end
        error_count   <= errors;
        pending_count <= expected_q.size();
        results_seen  <= seen;
    end

endmodule

[tb/white_pixel_edge_softener_tb.sv]
// ----------------------------------------------------------------------------
// white_pixel_edge_softener_tb
// Drives pixel writes, reads and softening passes into the edge softener over
// a series of image geometries, while a checker scores every result.
// ----------------------------------------------------------------------------
module white_pixel_edge_softener_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wse_pkg::*;

    localparam int MAX_W         = 512;
    localparam int MAX_H         = 512;
    localparam int ITEM_TARGET   = 1100;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int FILL_LIMIT    = 256;   // largest image that gets fully painted
    localparam int RECENT_DEPTH  = 64;
    localparam int GEOM_COUNT    = 12;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       opcode;
    logic [8:0]       pos_x;
    logic [8:0]       pos_y;
    logic [7:0]       red_in;
    logic [7:0]       green_in;
    logic [7:0]       blue_in;
    logic             result_valid;
    logic [7:0]       red_out;
    logic [7:0]       green_out;
    logic [7:0]       blue_out;
    logic             status;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_index;
    logic [DIM_W-1:0] cfg_data;

    int error_count;
    int pending_count;
    int results_seen;
    int cycle_count = 0;

    // stimulus-side bookkeeping: which pixels hold defined data, so that no
    // read and no pass ever touches an entry that was never written
    bit written [0:MAX_W*MAX_H-1];
    int recent_addr [$];
    int w_eff = MAX_W;
    int h_eff = MAX_H;
    bit filled;          // every pixel of the current geometry is defined
    int items_sent;
    int reads_sent;
    int passes_sent;
    int geometries;

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    white_pixel_edge_softener #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .result_valid (result_valid),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    white_pixel_edge_softener_checker #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .result_valid  (result_valid),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count),
        .results_seen  (results_seen)
    );

    // watchdog
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Colors biased toward white and toward 0xD7, which turns white after one
    // soften step, so passes create new white pixels as they sweep.
    function automatic pixel_t random_pixel();
        pixel_t p;
        int     roll;
        roll    = $urandom_range(99);
        p.red   = (roll < 35) ? WHITE_RED : (roll < 45) ? 8'hD7 : 8'($urandom);
        p.green = 8'($urandom);
        p.blue  = 8'($urandom);
        return p;
    endfunction

    // Idle share of the sender: heavy in the first third, heavier in the
    // second, none at the end so back-to-back transactions get covered too.
    function automatic int idle_percent();
        if (items_sent < ITEM_TARGET / 3)
            return 33;
        else if (items_sent < 2 * ITEM_TARGET / 3)
            return 54;
        return 0;
    endfunction

    // Table of geometries swept by the random part: empty, narrow, square,
    // oversized (saturating) and the full-size extremes.
    task automatic pick_geometry(input int k, output int w, output int h);
        case (k % GEOM_COUNT)
            0:  begin w = 6;    h = 5;    end
            1:  begin w = 1023; h = 1023; end
            2:  begin w = 2;    h = 7;    end
            3:  begin w = 8;    h = 8;    end
            4:  begin w = 0;    h = 300;  end
            5:  begin w = 11;   h = 1;    end
            6:  begin w = 4;    h = 4;    end
            7:  begin w = 512;  h = 3;    end
            8:  begin w = 1;    h = 9;    end
            9:  begin w = 16;   h = 12;   end
            10: begin w = 300;  h = 0;    end
            default: begin w = 3; h = 3;  end
        endcase
    endtask

    // Called at a falling edge. Presents one transaction and returns at the
    // falling edge after it was taken; start stays high for the caller.
    task automatic send(input logic [1:0] op, input int x, input int y, input pixel_t pix);
        int addr;
        if (idle_percent() != 0 && $urandom_range(99) < idle_percent())
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        start    <= 1'b1;
        opcode   <= op;
        pos_x    <= x[8:0];
        pos_y    <= y[8:0];
        red_in   <= pix.red;
        green_in <= pix.green;
        blue_in  <= pix.blue;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);

        addr = y * MAX_W + x;
        if (op == OP_WRITE && x < w_eff && y < h_eff)
        begin
            written[addr] = 1'b1;
            recent_addr.push_back(addr);
            if (recent_addr.size() > RECENT_DEPTH)
                void'(recent_addr.pop_front());
        end
        items_sent++;
        if (op == OP_READ)
            reads_sent++;
        if (op == OP_RUN)
            passes_sent++;
    endtask

    // Hold the sender off until the checker has nothing outstanding.
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
    endtask

    task automatic cfg_write(input logic idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[DIM_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // Geometry changes only while the block is quiet.
    task automatic set_geometry(input int w, input int h);
        drain();
        cfg_write(CFG_IDX_WIDTH, w);
        cfg_write(CFG_IDX_HEIGHT, h);
        cfg_valid <= 1'b0;
        w_eff  = (w > MAX_W) ? MAX_W : w;
        h_eff  = (h > MAX_H) ? MAX_H : h;
        filled = 1'b0;
        geometries++;
    endtask

    // Paint every pixel of the current image in raster order.
    task automatic paint_image();
        for (int y = 0; y < h_eff; y++)
            for (int x = 0; x < w_eff; x++)
                send(OP_WRITE, x, y, random_pixel());
        filled = 1'b1;
    endtask

    task automatic random_command();
        logic [1:0] op;
        int         roll;
        int         x;
        int         y;
        int         addr;
        bit         empty;
        bit         can_outside;
        roll        = $urandom_range(99);
        empty       = (w_eff == 0 || h_eff == 0);
        can_outside = (w_eff < MAX_W || h_eff < MAX_H);
        x           = $urandom_range(0, 511);
        y           = $urandom_range(0, 511);

        if (roll < 5)
            op = OP_IGNORED;
        else if ((filled || empty) && roll < 13)
            op = OP_RUN;
        else if (roll < 55)
            op = OP_WRITE;
        else
            op = OP_READ;

        if ((op == OP_WRITE || op == OP_READ) && !empty)
        begin
            if (can_outside && $urandom_range(99) < 15)
            begin
                // a coordinate past the configured edge
                if (w_eff < MAX_W && (h_eff == MAX_H || $urandom_range(1)))
                    x = $urandom_range(w_eff, 511);
                else
                    y = $urandom_range(h_eff, 511);
            end
            else
            begin
                x = $urandom_range(0, w_eff - 1);
                y = $urandom_range(0, h_eff - 1);
                // a read inside a partly painted image targets a recent write
                if (op == OP_READ && !written[y * MAX_W + x])
                begin
                    op = OP_WRITE;
                    if (recent_addr.size() != 0)
                    begin
                        addr = recent_addr[$urandom_range(0, recent_addr.size() - 1)];
                        if (addr % MAX_W < w_eff && addr / MAX_W < h_eff)
                        begin
                            x  = addr % MAX_W;
                            y  = addr / MAX_W;
                            op = OP_READ;
                        end
                    end
                end
            end
        end
        send(op, x, y, random_pixel());
    endtask

    initial
    begin
        pixel_t pix;
        int     geom_w;
        int     geom_h;
        int     phase_idx;

        rst_n     = 1'b0;
        start     = 1'b0;
        opcode    = OP_WRITE;
        pos_x     = '0;
        pos_y     = '0;
        red_in    = '0;
        green_in  = '0;
        blue_in   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IDX_WIDTH;
        cfg_data  = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---------------- directed part ----------------
        // Full 512x512 geometry out of reset: corner pixels, both extremes of
        // every field, and the ignored opcode.
        send(OP_WRITE, 511, 511, '{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
        send(OP_WRITE, 0, 0, '{red: 8'h00, green: 8'h00, blue: 8'h00});
        send(OP_READ, 511, 511, '0);
        send(OP_READ, 0, 0, '{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
        send(OP_IGNORED, 511, 511, '{red: 8'hFF, green: 8'hFF, blue: 8'hFF});

        // Oversized width saturates, zero height empties the image: every
        // access is rejected and a pass is a no-op.
        set_geometry(1023, 0);
        send(OP_WRITE, 5, 0, '{red: 8'h12, green: 8'h34, blue: 8'h56});
        send(OP_READ, 0, 0, '0);
        send(OP_RUN, 0, 0, '0);

        // 3x3 image with a white center; its upper neighbor starts at 0xD7 so
        // it turns white mid-pass, and blues near 0xFF wrap when bumped.
        set_geometry(3, 3);
        for (int y = 0; y < 3; y++)
        begin
            for (int x = 0; x < 3; x++)
            begin
                pix.red   = (x == 1 && y == 1) ? WHITE_RED :
                            (x == 1 && y == 0) ? 8'hD7 : 8'(8'h11 * (y * 3 + x));
                pix.green = 8'(8'hE0 + x);
                pix.blue  = 8'(8'hF0 + y * 3 + x);
                send(OP_WRITE, x, y, pix);
            end
        end
        filled = 1'b1;
        send(OP_RUN, 0, 0, '0);
        send(OP_READ, 1, 0, '0);
        send(OP_READ, 0, 1, '0);
        send(OP_WRITE, 3, 0, '{red: 8'hAA, green: 8'h55, blue: 8'hAA});
        send(OP_READ, 0, 3, '0);

        // Narrow image: two columns, one row, nothing is interior.
        set_geometry(2, 1);
        filled = 1'b1;
        send(OP_RUN, 0, 0, '0);
        send(OP_READ, 1, 0, '0);

        // ---------------- random part ----------------
        // Each phase reprograms the geometry, paints small images completely
        // so passes are legal, then mixes writes, reads, passes and noise.
        phase_idx = 0;
        while (items_sent < ITEM_TARGET)
        begin
            pick_geometry(phase_idx, geom_w, geom_h);
            set_geometry(geom_w, geom_h);
            if (w_eff * h_eff != 0 && w_eff * h_eff <= FILL_LIMIT)
                paint_image();
            repeat ($urandom_range(30, 90))
            begin
                // now and then hold off until every result is back
                if ($urandom_range(99) < 2)
                    drain();
                random_command();
            end
            phase_idx++;
        end

        // let the last results and any stray strobe show up
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d transactions (%0d reads, %0d softening passes) over %0d geometries",
                 items_sent, reads_sent, passes_sent, geometries);
        $display("%0d results scored, %0d mismatches", results_seen, error_count);
        if (error_count == 0 && pending_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
